// ===== design/tlv_journal_record_parser_defines.svh =====
// Assertion macros shared by the checker of the journal record parser.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef TLV_JOURNAL_RECORD_PARSER_DEFINES_SVH
`define TLV_JOURNAL_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TJRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tjrp assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TJRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tjrp assertion failed");

`endif

// ===== design/tjrp_pkg.sv =====
// Types, codes and helper functions of the journal record parser.
// Used by the parser core, the result queue, the top level and the checker.
package tjrp_pkg;

    // Input item: a stream byte or an end-of-segment mark.
    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key_id;
        logic [7:0]  value_type;
        logic [26:0] length;
        logic [15:0] field_total;
        logic [31:0] record_base;
        logic [7:0]  out_byte;
        logic        last_of_field;
        logic [1:0]  status;
    } result_t;

    // Results produced by one item, at most two, pushed into the queue together.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PhMagic,
        PhLen,
        PhCount,
        PhFhdr,
        PhValue,
        PhSkip,
        PhBadMagic
    } phase_e;

    // Input actions.
    localparam logic ActData   = 1'b0;
    localparam logic ActSegEnd = 1'b1;

    // Result kinds.
    localparam logic [1:0] KindHeader = 2'd0;
    localparam logic [1:0] KindField  = 2'd1;
    localparam logic [1:0] KindValue  = 2'd2;
    localparam logic [1:0] KindEnd    = 2'd3;

    // Record end status codes.
    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StIoError  = 2'd1;
    localparam logic [1:0] StTooMany  = 2'd2;
    localparam logic [1:0] StBadMagic = 2'd3;

    // Register indexes on the configuration port (address bit 2).
    localparam logic RegMaxRecordLen = 1'b0;
    localparam logic RegMaxFields    = 1'b1;
    localparam int   PaddrW          = 3;

    // Register reset values.
    localparam logic [26:0] MaxRecordLenReset = 27'(64 * 1024 * 1024);
    localparam logic [15:0] MaxFieldsReset    = 16'd64;

    // Stream constants.
    localparam logic [55:0] MagicHead     = 56'h5343524942454A;
    localparam logic [7:0]  MagicTail     = 8'h33;
    localparam logic [26:0] HardMaxLen    = 27'(64 * 1024 * 1024);
    localparam logic [2:0]  FieldHdrBytes = 3'd7;

    // Result queue geometry.
    localparam int ResultDepth = 4;
    localparam int PtrW        = $clog2(ResultDepth);
    localparam int CountW      = $clog2(ResultDepth + 1);

    // A record end or error result.
    function automatic result_t end_item(input logic [1:0] st, input logic [31:0] off);
        result_t r;
        r             = '0;
        r.kind        = KindEnd;
        r.status      = st;
        r.record_base = off;
        return r;
    endfunction

endpackage

// ===== design/tlv_journal_record_parser.sv =====
// Top level of the journal record parser: configuration registers, parser
// core and result queue. Depends on tjrp_pkg, tjrp_parser and tjrp_result_fifo.
//
//   channel   direction  handshake                      payload
//   item      in         item_valid / item_ready        item   (tjrp_pkg::item_t)
//   result    out        result_valid / result_ready    result (tjrp_pkg::result_t)
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each item is decoded in the cycle it is accepted; one item per cycle is taken
// while item_ready is high. An item yields zero, one or two results, written
// into a four-entry queue. It drains one result per cycle while result_ready
// is high, so item_ready drops while fewer than two queue entries are free.
// Reset is asynchronous and active low and needs no clearing pass.
module tlv_journal_record_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  tjrp_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output tjrp_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tjrp_pkg::PaddrW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [26:0]      max_record_len_reg;
    logic [15:0]      max_fields_reg;
    logic             cfg_write;
    logic             accept;
    logic             room;
    tjrp_pkg::push_t  push;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_record_len_reg <= tjrp_pkg::MaxRecordLenReset;
            max_fields_reg     <= tjrp_pkg::MaxFieldsReset;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                tjrp_pkg::RegMaxRecordLen: max_record_len_reg <= pwdata[26:0];
                tjrp_pkg::RegMaxFields:    max_fields_reg     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            tjrp_pkg::RegMaxRecordLen: prdata = {5'd0, max_record_len_reg};
            tjrp_pkg::RegMaxFields:    prdata = {16'd0, max_fields_reg};
            default:                   prdata = '0;
        endcase
    end

    assign item_ready = room;
    assign accept     = item_valid && item_ready;

    tjrp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item           (item),
        .max_record_len (max_record_len_reg),
        .max_fields     (max_fields_reg),
        .push           (push)
    );

    tjrp_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== design/tjrp_parser.sv =====
// Parser core of the journal record parser: phase and counter registers and
// the per-byte decode. Depends on tjrp_pkg.
module tjrp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  tjrp_pkg::item_t       item,
    input  logic [26:0]           max_record_len,
    input  logic [15:0]           max_fields,
    output tjrp_pkg::push_t       push
);

    tjrp_pkg::phase_e phase_reg, phase_next;
    logic [2:0]       idx_reg, idx_next;
    logic [55:0]      shift_reg, shift_next;
    logic [26:0]      rrem_reg, rrem_next;
    logic [26:0]      vrem_reg, vrem_next;
    logic [15:0]      fleft_reg, fleft_next;
    logic [1:0]       perr_reg, perr_next;
    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      rstart_reg, rstart_next;

    logic [7:0]       b;
    logic [26:0]      rr_dec;
    logic [26:0]      vr_dec;
    logic [15:0]      fl_dec;
    logic [26:0]      lim;
    logic [55:0]      base;
    logic [55:0]      sh;
    logic [31:0]      len32;
    logic [31:0]      vlen;
    logic             do_adv;
    logic [15:0]      fl_adv;
    tjrp_pkg::push_t  res;

    assign b      = item.in_byte;
    assign rr_dec = rrem_reg - 27'd1;
    assign vr_dec = vrem_reg - 27'd1;
    assign fl_dec = fleft_reg - 16'd1;
    assign lim    = (max_record_len < tjrp_pkg::HardMaxLen) ? max_record_len
                                                              : tjrp_pkg::HardMaxLen;

    // The length prefix starts from a clean shift register.
    assign base   = (phase_reg == tjrp_pkg::PhLen && idx_reg == 3'd0) ? 56'd0 : shift_reg;
    // Little-endian byte insert at the current byte index.
    assign sh     = base | (56'(b) << {idx_reg, 3'b000});
    assign len32  = sh[31:0];
    assign vlen   = sh[55:24];

    // Decode of one item into next state and up to two results.
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        shift_next  = shift_reg;
        rrem_next   = rrem_reg;
        vrem_next   = vrem_reg;
        fleft_next  = fleft_reg;
        perr_next   = perr_reg;
        pos_next    = pos_reg;
        rstart_next = rstart_reg;
        do_adv      = 1'b0;
        fl_adv      = fleft_reg;

        res                    = '0;
        res.first.record_base  = rstart_reg;
        res.second.record_base = rstart_reg;

        if (accept)
        begin
            if (item.action == tjrp_pkg::ActSegEnd)
            begin
                // A segment end outside a clean record boundary is an I/O error, unless the magic was bad.
                if (phase_reg != tjrp_pkg::PhBadMagic &&
                    !(phase_reg == tjrp_pkg::PhLen && idx_reg == 3'd0))
                begin
                    res.count = 2'd1;
                    res.first = tjrp_pkg::end_item(tjrp_pkg::StIoError, rstart_reg);
                end
                phase_next  = tjrp_pkg::PhMagic;
                idx_next    = 3'd0;
                shift_next  = '0;
                rrem_next   = '0;
                vrem_next   = '0;
                fleft_next  = '0;
                perr_next   = '0;
                pos_next    = '0;
                rstart_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 32'd1;
                case (phase_reg)
                    tjrp_pkg::PhMagic:
                    begin
                        if (idx_reg < tjrp_pkg::FieldHdrBytes)
                        begin
                            shift_next = {shift_reg[47:0], b};
                            idx_next   = idx_reg + 3'd1;
                        end
                        else if (shift_reg == tjrp_pkg::MagicHead && b == tjrp_pkg::MagicTail)
                        begin
                            phase_next = tjrp_pkg::PhLen;
                            idx_next   = 3'd0;
                            shift_next = '0;
                        end
                        else
                        begin
                            res.count  = 2'd1;
                            res.first  = tjrp_pkg::end_item(tjrp_pkg::StBadMagic, rstart_reg);
                            phase_next = tjrp_pkg::PhBadMagic;
                        end
                    end

                    tjrp_pkg::PhLen:
                    begin
                        if (idx_reg == 3'd0)
                        begin
                            rstart_next = pos_reg;
                        end
                        if (idx_reg == 3'd3)
                        begin
                            idx_next   = 3'd0;
                            shift_next = '0;
                            if (len32 < 32'd2 || len32 > 32'(lim))
                            begin
                                res.count = 2'd1;
                                res.first = tjrp_pkg::end_item(tjrp_pkg::StIoError, rstart_reg);
                                perr_next = tjrp_pkg::StOk;
                            end
                            else
                            begin
                                rrem_next  = len32[26:0];
                                phase_next = tjrp_pkg::PhCount;
                            end
                        end
                        else
                        begin
                            shift_next = sh;
                            idx_next   = idx_reg + 3'd1;
                        end
                    end

                    tjrp_pkg::PhCount:
                    begin
                        shift_next = sh;
                        idx_next   = idx_reg + 3'd1;
                        rrem_next  = rr_dec;
                        if (idx_reg == 3'd1)
                        begin
                            if (sh[15:0] > max_fields)
                            begin
                                perr_next = tjrp_pkg::StTooMany;
                                if (rr_dec == 27'd0)
                                begin
                                    res.count  = 2'd1;
                                    res.first  = tjrp_pkg::end_item(tjrp_pkg::StTooMany,
                                                                    rstart_reg);
                                    perr_next  = tjrp_pkg::StOk;
                                    phase_next = tjrp_pkg::PhLen;
                                    idx_next   = 3'd0;
                                end
                                else
                                begin
                                    phase_next = tjrp_pkg::PhSkip;
                                end
                            end
                            else
                            begin
                                res.count             = 2'd1;
                                res.first.kind        = tjrp_pkg::KindHeader;
                                res.first.length      = rr_dec + 27'd2;
                                res.first.field_total = sh[15:0];
                                fleft_next            = sh[15:0];
                                do_adv                = 1'b1;
                                fl_adv                = sh[15:0];
                            end
                        end
                    end

                    tjrp_pkg::PhFhdr:
                    begin
                        rrem_next = rr_dec;
                        shift_next = sh;
                        if (idx_reg == tjrp_pkg::FieldHdrBytes - 3'd1)
                        begin
                            fleft_next = fl_dec;
                            idx_next   = 3'd0;
                            if (vlen > 32'(rr_dec))
                            begin
                                // Value would run past the body.
                                perr_next = tjrp_pkg::StIoError;
                                if (rr_dec == 27'd0)
                                begin
                                    res.count  = 2'd1;
                                    res.first  = tjrp_pkg::end_item(tjrp_pkg::StIoError,
                                                                    rstart_reg);
                                    perr_next  = tjrp_pkg::StOk;
                                    phase_next = tjrp_pkg::PhLen;
                                end
                                else
                                begin
                                    phase_next = tjrp_pkg::PhSkip;
                                end
                            end
                            else
                            begin
                                res.count            = 2'd1;
                                res.first.kind       = tjrp_pkg::KindField;
                                res.first.key_id     = sh[15:0];
                                res.first.value_type = sh[23:16];
                                res.first.length     = vlen[26:0];
                                vrem_next            = vlen[26:0];
                                if (vlen == 32'd0)
                                begin
                                    do_adv = 1'b1;
                                    fl_adv = fl_dec;
                                end
                                else
                                begin
                                    phase_next = tjrp_pkg::PhValue;
                                end
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 3'd1;
                            if (rr_dec == 27'd0)
                            begin
                                // Field header cut short by the body end.
                                res.count  = 2'd1;
                                res.first  = tjrp_pkg::end_item(tjrp_pkg::StIoError, rstart_reg);
                                perr_next  = tjrp_pkg::StOk;
                                phase_next = tjrp_pkg::PhLen;
                                idx_next   = 3'd0;
                            end
                        end
                    end

                    tjrp_pkg::PhValue:
                    begin
                        res.count               = 2'd1;
                        res.first.kind          = tjrp_pkg::KindValue;
                        res.first.out_byte      = b;
                        res.first.last_of_field = (vrem_reg == 27'd1);
                        vrem_next               = vr_dec;
                        rrem_next               = rr_dec;
                        if (vr_dec == 27'd0)
                        begin
                            do_adv = 1'b1;
                            fl_adv = fleft_reg;
                        end
                    end

                    tjrp_pkg::PhSkip:
                    begin
                        rrem_next = rr_dec;
                        if (rr_dec == 27'd0)
                        begin
                            res.count  = 2'd1;
                            res.first  = tjrp_pkg::end_item(perr_reg, rstart_reg);
                            perr_next  = tjrp_pkg::StOk;
                            phase_next = tjrp_pkg::PhLen;
                            idx_next   = 3'd0;
                        end
                    end

                    default:
                    begin
                    end
                endcase

                // Move on after the record header or a complete field.
                if (do_adv)
                begin
                    if (fl_adv == 16'd0)
                    begin
                        if (rr_dec == 27'd0)
                        begin
                            res.count  = 2'd2;
                            res.second = tjrp_pkg::end_item(tjrp_pkg::StOk, rstart_reg);
                            perr_next  = tjrp_pkg::StOk;
                            phase_next = tjrp_pkg::PhLen;
                            idx_next   = 3'd0;
                        end
                        else
                        begin
                            // Bytes left after the last field.
                            perr_next  = tjrp_pkg::StIoError;
                            phase_next = tjrp_pkg::PhSkip;
                        end
                    end
                    else if (rr_dec == 27'd0)
                    begin
                        res.count  = 2'd2;
                        res.second = tjrp_pkg::end_item(tjrp_pkg::StIoError, rstart_reg);
                        perr_next  = tjrp_pkg::StOk;
                        phase_next = tjrp_pkg::PhLen;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        phase_next = tjrp_pkg::PhFhdr;
                        idx_next   = 3'd0;
                        shift_next = '0;
                    end
                end
            end
        end
    end

    assign push = res;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tjrp_pkg::PhMagic;
            idx_reg    <= '0;
            shift_reg  <= '0;
            rrem_reg   <= '0;
            vrem_reg   <= '0;
            fleft_reg  <= '0;
            perr_reg   <= '0;
            pos_reg    <= '0;
            rstart_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            rrem_reg   <= rrem_next;
            vrem_reg   <= vrem_next;
            fleft_reg  <= fleft_next;
            perr_reg   <= perr_next;
            pos_reg    <= pos_next;
            rstart_reg <= rstart_next;
        end
    end

endmodule

// ===== design/tjrp_result_fifo.sv =====
// Result queue of the journal record parser: takes up to two results a cycle
// and delivers one a cycle while result_ready is high. Depends on tjrp_pkg.
module tjrp_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  tjrp_pkg::push_t    push,
    output logic               room,
    output logic               result_valid,
    input  logic               result_ready,
    output tjrp_pkg::result_t  result
);

    tjrp_pkg::result_t                 mem_reg [tjrp_pkg::ResultDepth];
    logic [tjrp_pkg::PtrW-1:0]         wp_reg, wp_next;
    logic [tjrp_pkg::PtrW-1:0]         rp_reg, rp_next;
    logic [tjrp_pkg::CountW-1:0]       count_reg, count_next;
    logic [tjrp_pkg::PtrW-1:0]         wp_plus;
    logic                              pop;

    assign wp_plus      = wp_reg + tjrp_pkg::PtrW'(1);
    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = mem_reg[rp_reg];
    // Room for the largest burst one item can produce.
    assign room         = (count_reg <= tjrp_pkg::CountW'(tjrp_pkg::ResultDepth - 2));

    // Pointer and fill count update.
    always_comb
    begin
        wp_next    = wp_reg + tjrp_pkg::PtrW'(push.count);
        rp_next    = pop ? rp_reg + tjrp_pkg::PtrW'(1) : rp_reg;
        count_next = count_reg + tjrp_pkg::CountW'(push.count)
                     - tjrp_pkg::CountW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // Queue storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wp_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wp_plus] <= push.second;
        end
    end

endmodule

// ===== design/tjrp_checker.sv =====
// Port-level checks of the journal record parser, bound to the top level.
// Depends on tjrp_pkg and the assertion macros header.
`include "tlv_journal_record_parser_defines.svh"

module tjrp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input tjrp_pkg::result_t result
);

    // A stalled result item holds its place and contents.
    `TJRP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                      result_valid && $stable(result))

    // Only record ends carry a nonzero status.
    `TJRP_ASSERT_NOW(a_status_only_on_end, result_valid && result.status != tjrp_pkg::StOk,
                     result.kind == tjrp_pkg::KindEnd)

    // The last-byte mark appears only on value bytes.
    `TJRP_ASSERT_NOW(a_last_only_on_value, result_valid && result.last_of_field,
                     result.kind == tjrp_pkg::KindValue)

    // A record header always reports a body of at least two bytes.
    `TJRP_ASSERT_NOW(a_header_len, result_valid && result.kind == tjrp_pkg::KindHeader,
                     result.length >= 27'd2)

endmodule

bind tlv_journal_record_parser tjrp_checker u_checker (.*);

// ===== verif/tb_tlv_journal_record_parser.sv =====
// Testbench for tlv_journal_record_parser: drives journal segment bytes and segment ends,
// predicts every parse result in a behavioral parser and checks each result item in order.
// Depends on tjrp_pkg and the RTL of tlv_journal_record_parser only.
`timescale 1ns / 100ps

module tb_tlv_journal_record_parser;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic item_valid = 1'b0;
    logic item_ready;
    tjrp_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    tjrp_pkg::result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [tjrp_pkg::PaddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Behavioral copy of the parser state and its registers.
    tjrp_pkg::phase_e prs_phase = tjrp_pkg::PhMagic;
    logic [2:0] prs_index = '0;
    logic [55:0] prs_shift = '0;
    logic [26:0] rec_left = '0;
    logic [26:0] val_left = '0;
    logic [15:0] fields_left = '0;
    logic [1:0] pend_err = tjrp_pkg::StOk;
    logic [31:0] seg_pos = '0;
    logic [31:0] rec_start = '0;
    logic [26:0] cfg_max_len = tjrp_pkg::MaxRecordLenReset;
    logic [15:0] cfg_max_fields = tjrp_pkg::MaxFieldsReset;

    // Parse results that are still owed by the block, oldest first.
    tjrp_pkg::result_t parse_outputs[$];

    int fail_count = 0;
    int items_sent = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_left = 0;
    int rx_stall_left = 0;

    tlv_journal_record_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Global watchdog.
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void log_failure(string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    function automatic string result_text(tjrp_pkg::result_t r);
        return $sformatf({"kind=%0d key=%h type=%h len=%0d total=%0d base=%0d",
                          " byte=%h last=%b st=%0d"},
            r.kind, r.key_id, r.value_type, r.length, r.field_total, r.record_base,
            r.out_byte, r.last_of_field, r.status);
    endfunction

    // Effective body length limit: the register, capped at the hard maximum.
    function automatic logic [26:0] record_limit();
        return (cfg_max_len < tjrp_pkg::HardMaxLen) ? cfg_max_len : tjrp_pkg::HardMaxLen;
    endfunction

    function automatic logic [7:0] magic_byte(int idx);
        if (idx < 7)
        begin
            return tjrp_pkg::MagicHead[55 - 8 * idx -: 8];
        end
        return tjrp_pkg::MagicTail;
    endfunction

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------

    function automatic void post_result(logic [1:0] kind, logic [15:0] fkey, logic [7:0] vtype,
                                        logic [26:0] len, logic [15:0] total, logic [7:0] vbyte,
                                        logic last, logic [1:0] st);
        tjrp_pkg::result_t r;
        r = '0;
        r.kind = kind;
        r.key_id = fkey;
        r.value_type = vtype;
        r.length = len;
        r.field_total = total;
        r.record_base = rec_start;
        r.out_byte = vbyte;
        r.last_of_field = last;
        r.status = st;
        parse_outputs.push_back(r);
    endfunction

    function automatic void close_record(logic [1:0] st);
        post_result(tjrp_pkg::KindEnd, '0, '0, '0, '0, '0, 1'b0, st);
        pend_err = tjrp_pkg::StOk;
        prs_phase = tjrp_pkg::PhLen;
        prs_index = '0;
    endfunction

    // A field or the record header is complete: next field, close, or skip the rest.
    function automatic void next_field();
        if (fields_left == 16'd0)
        begin
            if (rec_left == 27'd0)
            begin
                close_record(tjrp_pkg::StOk);
            end
            else
            begin
                pend_err = tjrp_pkg::StIoError;
                prs_phase = tjrp_pkg::PhSkip;
            end
        end
        else if (rec_left == 27'd0)
        begin
            close_record(tjrp_pkg::StIoError);
        end
        else
        begin
            prs_phase = tjrp_pkg::PhFhdr;
            prs_index = '0;
            prs_shift = '0;
        end
    endfunction

    // Structural error: reported at once if the body is used up, else at its last byte.
    function automatic void fail_structure(logic [1:0] st);
        pend_err = st;
        if (rec_left == 27'd0)
        begin
            close_record(st);
        end
        else
        begin
            prs_phase = tjrp_pkg::PhSkip;
        end
    endfunction

    function automatic void parse_item(tjrp_pkg::item_t it);
        logic [31:0] word;
        logic [15:0] cnt;
        // A segment end reports an open magic or record and restarts the segment.
        if (it.action == tjrp_pkg::ActSegEnd)
        begin
            if (prs_phase != tjrp_pkg::PhBadMagic &&
                !(prs_phase == tjrp_pkg::PhLen && prs_index == 3'd0))
            begin
                post_result(tjrp_pkg::KindEnd, '0, '0, '0, '0, '0, 1'b0, tjrp_pkg::StIoError);
            end
            prs_phase = tjrp_pkg::PhMagic;
            prs_index = '0;
            prs_shift = '0;
            rec_left = '0;
            val_left = '0;
            fields_left = '0;
            pend_err = tjrp_pkg::StOk;
            seg_pos = '0;
            rec_start = '0;
            return;
        end
        case (prs_phase)
            tjrp_pkg::PhMagic:
            begin
                if (prs_index < 3'd7)
                begin
                    prs_shift = {prs_shift[47:0], it.in_byte};
                    prs_index = prs_index + 3'd1;
                end
                else if (prs_shift == tjrp_pkg::MagicHead && it.in_byte == tjrp_pkg::MagicTail)
                begin
                    prs_phase = tjrp_pkg::PhLen;
                    prs_index = '0;
                    prs_shift = '0;
                end
                else
                begin
                    post_result(tjrp_pkg::KindEnd, '0, '0, '0, '0, '0, 1'b0,
                                tjrp_pkg::StBadMagic);
                    prs_phase = tjrp_pkg::PhBadMagic;
                end
            end
            tjrp_pkg::PhLen:
            begin
                if (prs_index == 3'd0)
                begin
                    rec_start = seg_pos;
                    prs_shift = '0;
                end
                prs_shift = prs_shift | (56'(it.in_byte) << (8 * prs_index[1:0]));
                prs_index = prs_index + 3'd1;
                if (prs_index >= 3'd4)
                begin
                    word = prs_shift[31:0];
                    prs_index = '0;
                    prs_shift = '0;
                    if (word < 32'd2 || word > {5'd0, record_limit()})
                    begin
                        close_record(tjrp_pkg::StIoError);
                    end
                    else
                    begin
                        rec_left = word[26:0];
                        prs_phase = tjrp_pkg::PhCount;
                    end
                end
            end
            tjrp_pkg::PhCount:
            begin
                prs_shift = prs_shift | (56'(it.in_byte) << (8 * prs_index[0]));
                prs_index = prs_index + 3'd1;
                rec_left = rec_left - 27'd1;
                if (prs_index >= 3'd2)
                begin
                    cnt = prs_shift[15:0];
                    if (cnt > cfg_max_fields)
                    begin
                        fail_structure(tjrp_pkg::StTooMany);
                    end
                    else
                    begin
                        post_result(tjrp_pkg::KindHeader, '0, '0, rec_left + 27'd2, cnt, '0,
                                    1'b0, tjrp_pkg::StOk);
                        fields_left = cnt;
                        next_field();
                    end
                end
            end
            tjrp_pkg::PhFhdr:
            begin
                prs_shift = prs_shift | (56'(it.in_byte) << (8 * prs_index));
                prs_index = prs_index + 3'd1;
                rec_left = rec_left - 27'd1;
                if (prs_index >= tjrp_pkg::FieldHdrBytes)
                begin
                    word = prs_shift[55:24];
                    fields_left = fields_left - 16'd1;
                    prs_index = '0;
                    if (word > {5'd0, rec_left})
                    begin
                        fail_structure(tjrp_pkg::StIoError);
                    end
                    else
                    begin
                        post_result(tjrp_pkg::KindField, prs_shift[15:0], prs_shift[23:16],
                                    word[26:0], '0, '0, 1'b0, tjrp_pkg::StOk);
                        val_left = word[26:0];
                        if (word == 32'd0)
                        begin
                            next_field();
                        end
                        else
                        begin
                            prs_phase = tjrp_pkg::PhValue;
                        end
                    end
                end
                else if (rec_left == 27'd0)
                begin
                    close_record(tjrp_pkg::StIoError);
                end
            end
            tjrp_pkg::PhValue:
            begin
                post_result(tjrp_pkg::KindValue, '0, '0, '0, '0, it.in_byte,
                            val_left == 27'd1, tjrp_pkg::StOk);
                val_left = val_left - 27'd1;
                rec_left = rec_left - 27'd1;
                if (val_left == 27'd0)
                begin
                    next_field();
                end
            end
            tjrp_pkg::PhSkip:
            begin
                rec_left = rec_left - 27'd1;
                if (rec_left == 27'd0)
                begin
                    close_record(pend_err);
                end
            end
            default:
            begin
            end
        endcase
        seg_pos = seg_pos + 32'd1;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: predicts on every accepted item, checks every accepted result
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        tjrp_pkg::result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                parse_item(item);
            end
            if (result_valid && result_ready)
            begin
                if (parse_outputs.size() == 0)
                begin
                    log_failure({"unexpected result: ", result_text(result)});
                end
                else
                begin
                    want = parse_outputs.pop_front();
                    if (result.kind !== want.kind || result.key_id !== want.key_id ||
                        result.value_type !== want.value_type || result.length !== want.length ||
                        result.field_total !== want.field_total ||
                        result.record_base !== want.record_base ||
                        result.out_byte !== want.out_byte ||
                        result.last_of_field !== want.last_of_field ||
                        result.status !== want.status)
                    begin
                        log_failure({"result mismatch: expected ", result_text(want),
                                     " actual ", result_text(result)});
                    end
                end
            end
        end
    end

    // Result receiver: random stall bursts plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            result_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left != 0)
        begin
            result_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_idle_on && $urandom_range(0, 7) == 0)
        begin
            result_ready <= 1'b0;
            rx_stall_left = int'($urandom_range(0, 16));
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Shared drivers
    // ---------------------------------------------------------------

    // Offers one item and returns at the edge where it is taken; valid stays high.
    task automatic send_item(input logic act, input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 9) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= {act, b};
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result has come out.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (parse_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Writes one register, then reads it back to check the stored width.
    task automatic write_reg(input logic idx, input logic [31:0] data);
        logic [31:0] stored;
        stored = (idx == tjrp_pkg::RegMaxRecordLen) ? {5'd0, data[26:0]} : {16'd0, data[15:0]};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == tjrp_pkg::RegMaxRecordLen)
        begin
            cfg_max_len = stored[26:0];
        end
        else
        begin
            cfg_max_fields = stored[15:0];
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
        begin
            log_failure($sformatf("register %0d read %h, expected %h", idx, prdata, stored));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // One record: well formed most of the time, otherwise broken in one of several ways.
    task automatic send_record(output bit closed);
        logic [7:0] body[$];
        logic [31:0] blen;
        logic [15:0] cnt;
        int nfields;
        int vlen;
        int mode;
        int cut;
        int n;
        closed = 1'b0;
        nfields = $urandom_range(0, 3);
        mode = $urandom_range(0, 11);
        cnt = 16'(nfields);
        if (mode == 7)
        begin
            // Field count beyond the limit, or a huge count the body cannot hold.
            cnt = (cfg_max_fields == 16'hFFFF || $urandom_range(0, 1) == 0) ?
                  16'hFFFF : cfg_max_fields + 16'd1;
        end
        body.push_back(cnt[7:0]);
        body.push_back(cnt[15:8]);
        repeat (nfields)
        begin
            vlen = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            repeat (3) body.push_back(8'($urandom));
            for (n = 0; n < 4; n++)
            begin
                body.push_back(8'(vlen >> (8 * n)));
            end
            repeat (vlen) body.push_back(8'($urandom));
        end
        if (mode == 4)
        begin
            // Stray bytes after the last field.
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        end
        else if (mode == 5 && body.size() > 3)
        begin
            // Body cut short: truncated field header or value running past the body.
            repeat ($urandom_range(1, body.size() - 3)) void'(body.pop_back());
        end
        blen = 32'(body.size());
        if (mode == 6)
        begin
            // Length prefix out of range.
            case ($urandom_range(0, 3))
                0: blen = 32'd0;
                1: blen = 32'd1;
                2: blen = {5'd0, record_limit()} + 32'd1;
                default: blen = $urandom | 32'h0800_0000;
            endcase
        end
        if (mode == 11)
        begin
            // The segment ends inside this record, maybe inside its length prefix.
            cut = $urandom_range(1, 3 + body.size());
            for (n = 0; n < cut; n++)
            begin
                if (n < 4)
                begin
                    send_item(tjrp_pkg::ActData, blen[8 * n +: 8]);
                end
                else
                begin
                    send_item(tjrp_pkg::ActData, body[n - 4]);
                end
            end
            send_item(tjrp_pkg::ActSegEnd, 8'($urandom));
            closed = 1'b1;
            return;
        end
        for (n = 0; n < 4; n++)
        begin
            send_item(tjrp_pkg::ActData, blen[8 * n +: 8]);
        end
        if (blen >= 32'd2 && blen <= {5'd0, record_limit()})
        begin
            foreach (body[i])
            begin
                send_item(tjrp_pkg::ActData, body[i]);
            end
        end
    endtask

    // One segment: magic (sometimes bad or cut short), a few records, then its end.
    task automatic send_segment();
        int m;
        int k;
        int cut;
        int bad_at;
        bit closed;
        logic [7:0] b;
        m = $urandom_range(0, 15);
        if (m == 0)
        begin
            cut = $urandom_range(0, 7);
            for (k = 0; k < cut; k++)
            begin
                send_item(tjrp_pkg::ActData, magic_byte(k));
            end
            send_item(tjrp_pkg::ActSegEnd, 8'($urandom));
            return;
        end
        bad_at = (m == 1) ? $urandom_range(0, 7) : 8;
        for (k = 0; k < 8; k++)
        begin
            b = magic_byte(k);
            if (k == bad_at)
            begin
                b = b ^ 8'($urandom_range(1, 255));
            end
            send_item(tjrp_pkg::ActData, b);
        end
        if (m == 1)
        begin
            // Bytes after a bad magic are ignored until the segment ends.
            repeat ($urandom_range(0, 5)) send_item(tjrp_pkg::ActData, 8'($urandom));
            send_item(tjrp_pkg::ActSegEnd, 8'($urandom));
            return;
        end
        closed = 1'b0;
        repeat ($urandom_range(0, 4))
        begin
            if (!closed)
            begin
                send_record(closed);
            end
        end
        if (!closed)
        begin
            send_item(tjrp_pkg::ActSegEnd, 8'($urandom));
        end
    endtask

    task automatic send_segments(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            send_segment();
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // A good record with extreme key and value bytes, a bad length, a minimal
    // record, then a segment end between records.
    task automatic test_directed_records();
        logic [7:0] stream[$];
        int k;
        stream = '{8'h0B, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00,
                   8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        for (k = 0; k < 8; k++)
        begin
            send_item(tjrp_pkg::ActData, magic_byte(k));
        end
        foreach (stream[i])
        begin
            send_item(tjrp_pkg::ActData, stream[i]);
        end
        send_item(tjrp_pkg::ActSegEnd, 8'hFF);
    endtask

    // Random segments under a range of register settings, extremes included.
    task automatic test_register_settings();
        logic [31:0] len_settings[4];
        logic [31:0] count_settings[4];
        int k;
        len_settings = '{32'd2, 32'hFFFF_FFFF, 32'hF800_0030, 32'(tjrp_pkg::HardMaxLen)};
        count_settings = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0002,
                           32'(tjrp_pkg::MaxFieldsReset)};
        for (k = 0; k < 4; k++)
        begin
            wait_for_results();
            write_reg(tjrp_pkg::RegMaxRecordLen, len_settings[k]);
            write_reg(tjrp_pkg::RegMaxFields, count_settings[k]);
            send_segments(180);
        end
    endtask

    // The receiver holds off while a long value streams in, so the block fills
    // and stalls its input; afterwards the sender waits for every result.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_left = 300;
        for (int k = 0; k < 8; k++)
        begin
            send_item(tjrp_pkg::ActData, magic_byte(k));
        end
        send_item(tjrp_pkg::ActData, 8'd129);
        repeat (3) send_item(tjrp_pkg::ActData, 8'h00);
        send_item(tjrp_pkg::ActData, 8'h01);
        send_item(tjrp_pkg::ActData, 8'h00);
        repeat (3) send_item(tjrp_pkg::ActData, 8'($urandom));
        send_item(tjrp_pkg::ActData, 8'd120);
        repeat (3) send_item(tjrp_pkg::ActData, 8'h00);
        repeat (120) send_item(tjrp_pkg::ActData, 8'($urandom));
        send_item(tjrp_pkg::ActSegEnd, 8'($urandom));
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        wait_for_results();
        write_reg(tjrp_pkg::RegMaxRecordLen, 32'd100);
        write_reg(tjrp_pkg::RegMaxFields, 32'd3);
        send_segments(450);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_steady_stream();
        wait_for_results();
        write_reg(tjrp_pkg::RegMaxRecordLen, 32'(tjrp_pkg::MaxRecordLenReset));
        write_reg(tjrp_pkg::RegMaxFields, 32'(tjrp_pkg::MaxFieldsReset));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_segments(200);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_records();
        test_register_settings();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();
        wait_for_results();
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== tlv_journal_record_parser.f =====
+incdir+design
design/tjrp_pkg.sv
design/tjrp_parser.sv
design/tjrp_result_fifo.sv
design/tlv_journal_record_parser.sv
design/tjrp_checker.sv
verif/tb_tlv_journal_record_parser.sv
